/* src/ccwa_pkg.sv */
// ---------------------------------------------------------------------------
// ccwa_pkg
// Shared constants, flag bundle and arctangent table for the angle pipeline.
// ---------------------------------------------------------------------------
package ccwa_pkg;

  localparam int COORD_WIDTH_DEF   = 32;
  localparam int CORDIC_STAGES_DEF = 30;
  localparam int NORM_BITS         = 40;
  localparam int CD_W              = NORM_BITS + 3;  // cordic x/y with growth headroom
  localparam int Z_W               = 34;             // angle accumulator
  localparam int ANG_W             = 32;
  localparam int TOL_W             = 29;

  localparam logic [TOL_W-1:0]      TOL_RESET = 29'd268;
  localparam logic signed [Z_W-1:0] TWO_PI_Q  = 34'sd1686629713;
  localparam logic signed [Z_W-1:0] HALF_PI_Q = 34'sd421657428;

  typedef struct packed {
    logic mirror;
    logic both_zero;
    logic d_neg;
    logic p_neg;
    logic p_zero;
  } ccwa_flags_t;

  // atan(2^-i) in Q6.28, rounded
  function automatic logic signed [Z_W-1:0] atan_step(input int i);
    logic signed [Z_W-1:0] r;
    case (i)
      0:       r = 34'sd210828714;
      1:       r = 34'sd124459457;
      2:       r = 34'sd65760959;
      3:       r = 34'sd33381290;
      4:       r = 34'sd16755422;
      5:       r = 34'sd8385879;
      6:       r = 34'sd4193963;
      7:       r = 34'sd2097109;
      8:       r = 34'sd1048571;
      9:       r = 34'sd524287;
      10:      r = 34'sd262144;
      11:      r = 34'sd131072;
      default: r = (i <= 28) ? (34'sd1 <<< (28 - i)) : 34'sd0;
    endcase
    return r;
  endfunction

endpackage

/* src/ccwa_prep.sv */
// ---------------------------------------------------------------------------
// ccwa_prep
// Dot and cross products, magnitudes and common normalization to 40 bits.
// ---------------------------------------------------------------------------
module ccwa_prep #(
  parameter int COORD_WIDTH = ccwa_pkg::COORD_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             ce,
  input  logic                             in_valid,
  input  logic signed [COORD_WIDTH-1:0]    nx,
  input  logic signed [COORD_WIDTH-1:0]    ny,
  input  logic signed [COORD_WIDTH-1:0]    px,
  input  logic signed [COORD_WIDTH-1:0]    py,
  input  logic                             mirror,
  output logic                             out_valid,
  output logic [ccwa_pkg::NORM_BITS-1:0]   x_mag,
  output logic [ccwa_pkg::NORM_BITS-1:0]   y_mag,
  output ccwa_pkg::ccwa_flags_t            flags
);
  import ccwa_pkg::*;

  localparam int PW  = 2 * COORD_WIDTH;
  localparam int SW  = PW + 1;
  localparam int MW  = PW;
  localparam int LW  = $clog2(MW + 1);
  localparam int SHW = MW + NORM_BITS;

  logic [5:0] v_r;

  logic signed [COORD_WIDTH-1:0] nx_r, ny_r, px_r, py_r;
  logic                          mir1_r, mir2_r, mir3_r;
  logic signed [PW-1:0]          pa_r, pb_r, pc_r, pd_r;
  logic signed [SW-1:0]          dot_r, perp_r;
  logic [MW-1:0]                 dm4_r, pm4_r, dm5_r, pm5_r;
  ccwa_flags_t                   f4_r, f5_r, f6_r;
  logic [LW-1:0]                 len_nxt, len_r;
  logic [SHW-1:0]                dsh, psh;
  logic [NORM_BITS-1:0]          xm_r, ym_r;
  logic [MW-1:0]                 big_or;
  logic signed [SW-1:0]          dot_neg, perp_neg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (ce) begin
      v_r <= {v_r[4:0], in_valid};
    end
  end

  assign dot_neg  = -dot_r;
  assign perp_neg = -perp_r;

  // bit length of the larger magnitude
  assign big_or = dm4_r | pm4_r;
  always_comb begin
    len_nxt = '0;
    for (int i = 0; i < MW; i++) begin
      if (big_or[i]) len_nxt = LW'(i + 1);
    end
  end

  // floor(m * 2^(NORM_BITS - len)) for both parts
  assign dsh = {dm5_r, {NORM_BITS{1'b0}}} >> len_r;
  assign psh = {pm5_r, {NORM_BITS{1'b0}}} >> len_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      nx_r   <= nx;
      ny_r   <= ny;
      px_r   <= px;
      py_r   <= py;
      mir1_r <= mirror;

      pa_r   <= PW'(px_r) * PW'(nx_r);
      pb_r   <= PW'(py_r) * PW'(ny_r);
      pc_r   <= PW'(py_r) * PW'(nx_r);
      pd_r   <= PW'(px_r) * PW'(ny_r);
      mir2_r <= mir1_r;

      dot_r  <= SW'(pa_r) + SW'(pb_r);
      perp_r <= SW'(pc_r) - SW'(pd_r);
      mir3_r <= mir2_r;

      dm4_r <= dot_r[SW-1]  ? MW'(dot_neg)  : MW'(dot_r);
      pm4_r <= perp_r[SW-1] ? MW'(perp_neg) : MW'(perp_r);
      f4_r.mirror    <= mir3_r;
      f4_r.d_neg     <= dot_r[SW-1];
      f4_r.p_neg     <= perp_r[SW-1];
      f4_r.p_zero    <= (perp_r == '0);
      f4_r.both_zero <= (perp_r == '0) && (dot_r == '0);

      len_r <= len_nxt;
      dm5_r <= dm4_r;
      pm5_r <= pm4_r;
      f5_r  <= f4_r;

      xm_r <= dsh[NORM_BITS-1:0];
      ym_r <= psh[NORM_BITS-1:0];
      f6_r <= f5_r;
    end
  end

  assign out_valid = v_r[5];
  assign x_mag     = xm_r;
  assign y_mag     = ym_r;
  assign flags     = f6_r;

endmodule

/* src/ccwa_cordic.sv */
// ---------------------------------------------------------------------------
// ccwa_cordic
// Vectoring CORDIC: sign restore, quarter-turn prerotation, one stage per step.
// ---------------------------------------------------------------------------
module ccwa_cordic #(
  parameter int CORDIC_STAGES = ccwa_pkg::CORDIC_STAGES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               ce,
  input  logic                               in_valid,
  input  logic [ccwa_pkg::NORM_BITS-1:0]     x_mag,
  input  logic [ccwa_pkg::NORM_BITS-1:0]     y_mag,
  input  ccwa_pkg::ccwa_flags_t              in_flags,
  output logic                               out_valid,
  output logic signed [ccwa_pkg::Z_W-1:0]    angle,
  output ccwa_pkg::ccwa_flags_t              out_flags
);
  import ccwa_pkg::*;

  localparam int N = CORDIC_STAGES;

  logic signed [CD_W-1:0] xs_r, ys_r;
  ccwa_flags_t            fs_r;
  logic                   vs_r;

  logic signed [CD_W-1:0] x_r [0:N];
  logic signed [CD_W-1:0] y_r [0:N];
  logic signed [Z_W-1:0]  z_r [0:N];
  ccwa_flags_t            f_r [0:N];
  logic [N:0]             v_r;

  logic signed [CD_W-1:0] xe, ye;

  assign xe = CD_W'(x_mag);
  assign ye = CD_W'(y_mag);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs_r <= 1'b0;
      v_r  <= '0;
    end else if (ce) begin
      vs_r <= in_valid;
      v_r  <= {v_r[N-1:0], vs_r};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      xs_r <= in_flags.d_neg ? -xe : xe;
      ys_r <= in_flags.p_neg ? -ye : ye;
      fs_r <= in_flags;

      f_r[0] <= fs_r;
      if (xs_r < 0) begin
        if (ys_r >= 0) begin
          x_r[0] <= ys_r;
          y_r[0] <= -xs_r;
          z_r[0] <= HALF_PI_Q;
        end else begin
          x_r[0] <= -ys_r;
          y_r[0] <= xs_r;
          z_r[0] <= -HALF_PI_Q;
        end
      end else begin
        x_r[0] <= xs_r;
        y_r[0] <= ys_r;
        z_r[0] <= '0;
      end
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam logic signed [Z_W-1:0] ATAN_K = atan_step(k);
    logic signed [CD_W-1:0] xsh, ysh;
    assign xsh = x_r[k] >>> k;
    assign ysh = y_r[k] >>> k;
    always_ff @(posedge clk) begin
      if (ce) begin
        f_r[k+1] <= f_r[k];
        if (y_r[k] > 0) begin
          x_r[k+1] <= x_r[k] + ysh;
          y_r[k+1] <= y_r[k] - xsh;
          z_r[k+1] <= z_r[k] + ATAN_K;
        end else begin
          x_r[k+1] <= x_r[k] - ysh;
          y_r[k+1] <= y_r[k] + xsh;
          z_r[k+1] <= z_r[k] - ATAN_K;
        end
      end
    end
  end

  assign out_valid = v_r[N];
  assign angle     = z_r[N];
  assign out_flags = f_r[N];

endmodule

/* src/ccwa_post.sv */
// ---------------------------------------------------------------------------
// ccwa_post
// Near-zero trap, wrap into 0..2*pi, mirror for -Z normal; output register.
// ---------------------------------------------------------------------------
module ccwa_post (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              ce,
  input  logic                              in_valid,
  input  logic signed [ccwa_pkg::Z_W-1:0]   angle,
  input  ccwa_pkg::ccwa_flags_t             flags,
  input  logic [ccwa_pkg::TOL_W-1:0]        tol,
  output logic                              out_valid,
  output logic [ccwa_pkg::ANG_W-1:0]        angle_rad
);
  import ccwa_pkg::*;

  logic signed [Z_W-1:0] tol_s, a1_r, m;
  logic                  trap, v1_r, v2_r, zr_r, mir_r;
  logic [ANG_W-1:0]      ang_r;

  assign tol_s = Z_W'(tol);
  assign trap  = (angle > -tol_s) && (angle < tol_s);
  assign m     = mir_r ? (TWO_PI_Q - a1_r) : a1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (ce) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      // after a trap add the value is positive, so at most one 2*pi is added
      a1_r  <= angle + ((trap || angle < 0) ? TWO_PI_Q : '0);
      zr_r  <= flags.both_zero || (trap && !flags.p_neg && !flags.p_zero);
      mir_r <= flags.mirror;

      ang_r <= (zr_r || m < 0) ? '0 : m[ANG_W-1:0];
    end
  end

  assign out_valid = v2_r;
  assign angle_rad = ang_r;

endmodule

/* src/ccw_angle_between_2d_vectors.sv */
// Throughput: one beat per cycle; the whole pipeline advances together, set by
// the output register's handshake.
// Reset: synchronous active-low rst_n clears all valid bits and sets the
// tolerance register to 268.
// ---------------------------------------------------------------------------
// ccw_angle_between_2d_vectors
// Counterclockwise angle between two planar vectors, Q4.28 radians.
// ---------------------------------------------------------------------------
module ccw_angle_between_2d_vectors #(
  parameter int COORD_WIDTH   = ccwa_pkg::COORD_WIDTH_DEF,
  parameter int CORDIC_STAGES = ccwa_pkg::CORDIC_STAGES_DEF,
  parameter int IN_TDATA_W    = ((4 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // next_x, next_y, prev_x, prev_y (COORD_WIDTH each, from bit 0 up)
  input  logic [IN_TDATA_W-1:0]         in_tdata,
  // normal_negative
  input  logic                          in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // angle_rad
  output logic [ccwa_pkg::ANG_W-1:0]    out_tdata,
  input  logic                          cfg_wr_en,
  input  logic [ccwa_pkg::TOL_W-1:0]    cfg_wr_data
);
  import ccwa_pkg::*;

  logic [TOL_W-1:0]       tol_r;
  logic                   ce, p_valid, c_valid;
  logic [NORM_BITS-1:0]   x_mag, y_mag;
  ccwa_flags_t            p_flags, c_flags;
  logic signed [Z_W-1:0]  c_angle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_wr_en) begin
      tol_r <= cfg_wr_data;
    end
  end

  assign ce        = !out_tvalid || out_tready;
  assign in_tready = ce;

  ccwa_prep #(.COORD_WIDTH(COORD_WIDTH)) u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (in_tvalid),
    .nx        (in_tdata[COORD_WIDTH-1:0]),
    .ny        (in_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
    .px        (in_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH]),
    .py        (in_tdata[4*COORD_WIDTH-1:3*COORD_WIDTH]),
    .mirror    (in_tuser),
    .out_valid (p_valid),
    .x_mag     (x_mag),
    .y_mag     (y_mag),
    .flags     (p_flags)
  );

  ccwa_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (p_valid),
    .x_mag     (x_mag),
    .y_mag     (y_mag),
    .in_flags  (p_flags),
    .out_valid (c_valid),
    .angle     (c_angle),
    .out_flags (c_flags)
  );

  ccwa_post u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (c_valid),
    .angle     (c_angle),
    .flags     (c_flags),
    .tol       (tol_r),
    .out_valid (out_tvalid),
    .angle_rad (out_tdata)
  );

  a_rst_clears_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");
  // a concave trap can land up to one tolerance band above 2*pi
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata < ANG_W'(TWO_PI_Q) + (ANG_W'(1) << TOL_W))
    else $error("angle above 2*pi plus tolerance band");
  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("input taken during output stall");

endmodule
